// File: sv/lc3_pkg.sv
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types, codes and helpers for the LC-3 style instruction core.
// ----------------------------------------------------------------------------
package lc3_pkg;

  // word memory holds 2**ADDR_BITS words (valid range 14..16)
  localparam int ADDR_BITS = 16;

  typedef logic [ADDR_BITS-1:0] mem_addr_t;
  typedef logic [15:0]          word_t;
  typedef logic [2:0]           reg_idx_t;
  typedef logic [2:0]           flags_t;

  // commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // result status
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ILLEGAL = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // opcodes
  localparam logic [3:0] OP_BR  = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_LD  = 4'd2;
  localparam logic [3:0] OP_JSR = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_LDR = 4'd6;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_LDI = 4'd10;
  localparam logic [3:0] OP_JMP = 4'd12;
  localparam logic [3:0] OP_LEA = 4'd14;

  localparam flags_t   FLAG_P   = 3'b001;
  localparam flags_t   FLAG_Z   = 3'b010;
  localparam flags_t   FLAG_N   = 3'b100;
  localparam reg_idx_t REG_LINK = 3'd7;

  localparam word_t START_RESET = 16'h3000;

  typedef struct packed {
    logic [1:0] command;
    word_t      address;
    word_t      write_data;
    reg_idx_t   reg_select;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    word_t      pc_after;
    word_t      fetched_word;
    word_t      result_value;
    flags_t     flags;
  } out_beat_t;

  function automatic flags_t flags_of(input word_t v);
    flags_t f;
    if (v == '0) f = FLAG_Z;
    else if (v[15]) f = FLAG_N;
    else f = FLAG_P;
    return f;
  endfunction

endpackage

// File: sv/lc3_ram.sv
// ----------------------------------------------------------------------------
// lc3_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lc3_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: sv/lc3_regfile.sv
// ----------------------------------------------------------------------------
// lc3_regfile
// Eight 16-bit general registers: one read port with registered data, one
// write port. Per-entry valid bits make unwritten registers read as zero.
// ----------------------------------------------------------------------------
module lc3_regfile import lc3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  reg_idx_t rd_addr,
  output word_t    rd_data,
  input  logic     we,
  input  reg_idx_t wr_addr,
  input  word_t    wr_data
);

  word_t      mem [8];
  logic [7:0] valid;
  word_t      rd_q;
  logic       rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[rd_addr];
      if (we) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// File: sv/lc3_instruction_core_unit.sv
// ----------------------------------------------------------------------------
// lc3_instruction_core_unit
// LC-3 style core with private word memory, command driven, one result beat
// per command beat.
// ----------------------------------------------------------------------------
// One command is worked on at a time; the next is taken once the previous
// one has left the sequencer, while its result may still sit in the output
// register. Write, start and a refused execute finish in the idle state,
// a register read in the read-data state. Execute fetches from the word
// memory, then reads the one-port register file twice; LD and LDR add a
// data read, LDI a pointer and a data read, over the one word memory port.
// A result that cannot enter a full output register waits in a holding
// register until it can. Memory words never written read back undefined.
// ----------------------------------------------------------------------------
module lc3_instruction_core_unit import lc3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  word_t     cfg_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FETCH = 9'b000000010,
    S_RA    = 9'b000000100,
    S_RB    = 9'b000001000,
    S_EXEC  = 9'b000010000,
    S_MEM1  = 9'b000100000,
    S_MEM2  = 9'b001000000,
    S_RDREG = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t    state, state_next;
  word_t     pc, pc_next;
  flags_t    flags, flags_next;
  logic      halted, halted_next;
  word_t     start_address;
  word_t     ir, opa, opb;
  out_beat_t pend, fin_beat;

  logic       in_fire, slot_free;
  logic       fin, wb;
  logic [1:0] fin_status;
  word_t      fin_fetched, fin_result, wb_val;

  logic      ram_en, ram_we;
  mem_addr_t ram_addr;
  word_t     ram_wdata, ram_rdata;

  reg_idx_t rf_rd_addr, rf_wr_addr;
  word_t    rf_rd_data, rf_wr_data;
  logic     rf_we;

  logic [3:0] op;
  reg_idx_t   dr;
  word_t      off9, off6, off11, operand2, addr_calc;

  assign op       = ir[15:12];
  assign dr       = ir[11:9];
  assign off9     = {{7{ir[8]}}, ir[8:0]};
  assign off6     = {{10{ir[5]}}, ir[5:0]};
  assign off11    = {{5{ir[10]}}, ir[10:0]};
  assign operand2 = ir[5] ? {{11{ir[4]}}, ir[4:0]} : opb;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  lc3_ram #(.ADDR_W(ADDR_BITS), .DATA_W(16)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lc3_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rf_rd_addr),
    .rd_data (rf_rd_data),
    .we      (rf_we),
    .wr_addr (rf_wr_addr),
    .wr_data (rf_wr_data)
  );

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    flags_next  = flags;
    halted_next = halted;
    fin         = 1'b0;
    fin_status  = ST_DONE;
    fin_fetched = '0;
    fin_result  = '0;
    wb          = 1'b0;
    wb_val      = '0;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = pc[ADDR_BITS-1:0];
    ram_wdata   = in_data.write_data;
    rf_rd_addr  = ir[2:0];
    rf_we       = 1'b0;
    rf_wr_addr  = dr;
    rf_wr_data  = '0;
    addr_calc   = pc + off9;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.command)
            CMD_WRITE: begin
              ram_en   = 1'b1;
              ram_we   = 1'b1;
              ram_addr = in_data.address[ADDR_BITS-1:0];
              fin      = 1'b1;
            end
            CMD_START: begin
              pc_next     = start_address;
              halted_next = 1'b0;
              fin         = 1'b1;
            end
            CMD_READ: begin
              rf_rd_addr = in_data.reg_select;
              state_next = S_RDREG;
            end
            CMD_EXEC: begin
              if (halted) begin
                fin        = 1'b1;
                fin_status = ST_REFUSED;
              end else begin
                ram_en     = 1'b1;
                state_next = S_FETCH;
              end
            end
          endcase
        end
      end
      S_RDREG: begin
        fin        = 1'b1;
        fin_result = rf_rd_data;
      end
      S_FETCH: begin
        rf_rd_addr = ram_rdata[8:6];
        pc_next    = pc + 16'd1;
        state_next = S_RA;
      end
      S_RA: begin
        state_next = S_RB;
      end
      S_RB: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        fin_fetched = ir;
        unique case (op)
          OP_BR: begin
            fin = 1'b1;
            if (|(dr & flags)) pc_next = pc + off9;
          end
          OP_ADD: begin
            wb     = 1'b1;
            wb_val = opa + operand2;
          end
          OP_AND: begin
            wb     = 1'b1;
            wb_val = opa & operand2;
          end
          OP_NOT: begin
            wb     = 1'b1;
            wb_val = ~opa;
          end
          OP_LEA: begin
            wb     = 1'b1;
            wb_val = addr_calc;
          end
          OP_LD, OP_LDI: begin
            ram_en     = 1'b1;
            ram_addr   = addr_calc[ADDR_BITS-1:0];
            state_next = S_MEM1;
          end
          OP_LDR: begin
            addr_calc  = opa + off6;
            ram_en     = 1'b1;
            ram_addr   = addr_calc[ADDR_BITS-1:0];
            state_next = S_MEM1;
          end
          OP_JSR: begin
            // link is written after the base register was already read
            rf_we      = 1'b1;
            rf_wr_addr = REG_LINK;
            rf_wr_data = pc;
            pc_next    = ir[11] ? pc + off11 : opa;
            fin_result = pc;
            fin        = 1'b1;
          end
          OP_JMP: begin
            pc_next = opa;
            fin     = 1'b1;
          end
          default: begin
            halted_next = 1'b1;
            fin_status  = ST_ILLEGAL;
            fin         = 1'b1;
          end
        endcase
      end
      S_MEM1: begin
        fin_fetched = ir;
        if (op == OP_LDI) begin
          ram_en     = 1'b1;
          ram_addr   = ram_rdata[ADDR_BITS-1:0];
          state_next = S_MEM2;
        end else begin
          wb     = 1'b1;
          wb_val = ram_rdata;
        end
      end
      S_MEM2: begin
        fin_fetched = ir;
        wb          = 1'b1;
        wb_val      = ram_rdata;
      end
      S_OUT: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (wb) begin
      rf_we      = 1'b1;
      rf_wr_data = wb_val;
      flags_next = flags_of(wb_val);
      fin_result = wb_val;
      fin        = 1'b1;
    end

    if (fin) begin
      state_next = slot_free ? S_IDLE : S_OUT;
    end

    fin_beat = '{status:       fin_status,
                 pc_after:     pc_next,
                 fetched_word: fin_fetched,
                 result_value: fin_result,
                 flags:        flags_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pc            <= START_RESET;
      flags         <= FLAG_Z;
      halted        <= 1'b0;
      start_address <= START_RESET;
      out_valid     <= 1'b0;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      flags  <= flags_next;
      halted <= halted_next;
      if (cfg_we) start_address <= cfg_data;
      if ((fin || state == S_OUT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FETCH) ir <= ram_rdata;
    if (state == S_RA) opa <= rf_rd_data;
    if (state == S_RB) opb <= rf_rd_data;
    if (fin && !slot_free) pend <= fin_beat;
    if (fin && slot_free) begin
      out_data <= fin_beat;
    end else if (state == S_OUT && slot_free) begin
      out_data <= pend;
    end
  end

  // holding register only used while the output beat is still pending
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> out_valid)
    else $error("holding state without a pending output beat");

  a_halt_src: assert property (@(posedge clk) disable iff (rst)
    $rose(halted) |-> $past(state == S_EXEC))
    else $error("halt raised outside instruction execute");

  a_rf_order: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> !(state == S_FETCH || state == S_RA || state == S_RB))
    else $error("register write overlaps operand reads");

  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(flags))
    else $error("condition flags not one-hot");

endmodule
